[rtl/rsts_pkg.sv]
// ----------------------------------------------------------------------------
// rsts_pkg
// Shared types and constants for the row store table scan block.
// ----------------------------------------------------------------------------
package rsts_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 8;

  localparam int CMD_W   = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 3;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 4;
  // wide enough for an effective column count up to 16
  localparam int NCOL_W  = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(8);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_SCAN   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

endpackage

[rtl/row_store_table_scan.sv]
// ----------------------------------------------------------------------------
// row_store_table_scan
// Row-major cell table with insert, update, read and equality scan commands.
// ----------------------------------------------------------------------------
// Insert and update pass from accept through S_EXEC to a registered result;
// a read adds S_RDATA for the memory read. An equality scan decodes in S_EXEC,
// then walks the committed rows through the single read port of the cell
// memory, one row per cycle while the result side does not stall, compares
// each read value, loads the final beat and hands it over.
// A scan emits one beat per matching row in ascending order, tlast on the
// final one, or a single no-match beat. The block takes one command at a time;
// s_tready is high only between commands. The cell memory needs no clearing
// after reset.
module row_store_table_scan #(
  parameter int MAX_ROWS    = rsts_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = rsts_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [rsts_pkg::CFG_W-1:0]       cfg_wr_data,  // columns_in_use
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // command[1:0], row[7:2], column[10:8], value[42:11], zero fill
  input  logic [rsts_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // row_index[5:0], value_res[37:6], status[39:38]
  output logic [rsts_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import rsts_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int CUR_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW1    = ROW_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RDATA, S_SCAN} state_t;

  state_t               state;
  logic [CFG_W-1:0]     cols;
  logic [RC_W-1:0]      row_count;
  logic [CUR_W-1:0]     cursor;
  cmd_t                 cmd;
  logic [ROW_W-1:0]     cmd_row;
  logic [COL_W-1:0]     cmd_col;
  logic [VALUE_W-1:0]   cmd_value;

  logic [VALUE_W-1:0]   mem [DEPTH];
  logic [VALUE_W-1:0]   rdata;

  logic [RC_W-1:0]      scan_row;
  logic [ADDR_W-1:0]    scan_addr;
  logic                 cmp_valid;
  logic [ROW_W-1:0]     cmp_row;
  logic                 pend_valid;
  logic [ROW_W-1:0]     pend_row;

  logic                 o_valid;
  logic [ROW_W-1:0]     o_row;
  logic [VALUE_W-1:0]   o_value;
  status_t              o_status;
  logic                 o_last;

  logic [NCOL_W-1:0]    eff_cols;
  logic                 can_push;
  logic                 hit;
  logic                 full;
  logic                 range_err;
  logic                 col_err;
  logic                 commit;
  logic                 issue;
  logic                 stall;
  logic                 scan_done;
  logic [ADDR_W-1:0]    cell_addr;
  logic [ADDR_W-1:0]    ins_addr;

  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 push;
  logic [ROW_W-1:0]     push_row;
  logic [VALUE_W-1:0]   push_value;
  status_t              push_status;
  logic                 push_last;

  always_comb begin
    if (cols == '0) begin
      eff_cols = NCOL_W'(1);
    end else if (NCOL_W'(cols) > NCOL_W'(MAX_COLUMNS)) begin
      eff_cols = NCOL_W'(MAX_COLUMNS);
    end else begin
      eff_cols = NCOL_W'(cols);
    end
  end

  assign can_push  = !o_valid || m_tready;
  assign hit       = (rdata == cmd_value);
  assign full      = (row_count >= RC_W'(MAX_ROWS));
  assign col_err   = (NCOL_W'(cmd_col) >= eff_cols);
  assign range_err = (RW1'(cmd_row) >= RW1'(row_count)) || col_err;
  assign commit    = (NCOL_W'(cursor) + NCOL_W'(1) >= eff_cols);
  assign cell_addr = ADDR_W'(int'(cmd_row) * MAX_COLUMNS + int'(cmd_col));
  assign ins_addr  = ADDR_W'(int'(row_count) * MAX_COLUMNS + int'(cursor));
  assign issue     = (scan_row < row_count);
  assign stall     = cmp_valid && hit && pend_valid && !can_push;
  assign scan_done = !cmp_valid && !issue;

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = cell_addr;
    rd_en       = 1'b0;
    rd_addr     = cell_addr;
    push        = 1'b0;
    push_row    = '0;
    push_value  = '0;
    push_status = ST_OK;
    push_last   = 1'b1;
    unique case (state)
      S_EXEC: begin
        unique case (cmd)
          CMD_INSERT: begin
            push    = can_push;
            wr_addr = ins_addr;
            if (full) begin
              push_status = ST_FULL;
            end else begin
              wr_en    = can_push;
              push_row = ROW_W'(row_count);
            end
          end
          CMD_UPDATE: begin
            push = can_push;
            if (range_err) begin
              push_status = ST_RANGE;
            end else begin
              wr_en    = can_push;
              push_row = cmd_row;
            end
          end
          CMD_READ: begin
            if (range_err) begin
              push        = can_push;
              push_status = ST_RANGE;
            end else begin
              rd_en = 1'b1;
            end
          end
          CMD_SCAN: begin
            if (col_err) begin
              push        = can_push;
              push_status = ST_RANGE;
            end
          end
        endcase
      end
      S_RDATA: begin
        push       = can_push;
        push_row   = cmd_row;
        push_value = rdata;
      end
      S_SCAN: begin
        rd_addr = scan_addr;
        if (scan_done) begin
          push = can_push;
          if (pend_valid) begin
            push_row = pend_row;
          end else begin
            push_status = ST_NOMATCH;
          end
        end else if (!stall) begin
          rd_en = issue;
          if (cmp_valid && hit && pend_valid) begin
            push      = 1'b1;
            push_row  = pend_row;
            push_last = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cols       <= COLS_RESET;
      row_count  <= '0;
      cursor     <= '0;
      o_valid    <= 1'b0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cols <= cfg_wr_data;
      end

      if (push) begin
        o_valid  <= 1'b1;
        o_row    <= push_row;
        o_value  <= push_value;
        o_status <= push_status;
        o_last   <= push_last;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd       <= cmd_t'(s_tdata[1:0]);
            cmd_row   <= s_tdata[7:2];
            cmd_col   <= s_tdata[10:8];
            cmd_value <= s_tdata[42:11];
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd)
            CMD_INSERT: begin
              if (can_push) begin
                if (!full) begin
                  if (commit) begin
                    cursor    <= '0;
                    row_count <= row_count + RC_W'(1);
                  end else begin
                    cursor <= cursor + CUR_W'(1);
                  end
                end
                state <= S_IDLE;
              end
            end
            CMD_UPDATE: begin
              if (can_push) begin
                state <= S_IDLE;
              end
            end
            CMD_READ: begin
              if (!range_err) begin
                state <= S_RDATA;
              end else if (can_push) begin
                state <= S_IDLE;
              end
            end
            CMD_SCAN: begin
              if (!col_err) begin
                scan_row   <= '0;
                scan_addr  <= ADDR_W'(cmd_col);
                cmp_valid  <= 1'b0;
                pend_valid <= 1'b0;
                state      <= S_SCAN;
              end else if (can_push) begin
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_RDATA: begin
          if (can_push) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (can_push) begin
              state <= S_IDLE;
            end
          end else if (!stall) begin
            cmp_valid <= issue;
            if (issue) begin
              cmp_row   <= ROW_W'(scan_row);
              scan_row  <= scan_row + RC_W'(1);
              scan_addr <= scan_addr + ADDR_W'(MAX_COLUMNS);
            end
            if (cmp_valid && hit) begin
              pend_valid <= 1'b1;
              pend_row   <= cmp_row;
            end
          end
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {o_status, o_value, o_row};

`ifndef SYNTHESIS
  a_rows_bounded: assert property (@(posedge clk) disable iff (rst)
    row_count <= RC_W'(MAX_ROWS))
    else $error("row count beyond table capacity");

  a_nomatch_form: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status == ST_NOMATCH |-> o_last && o_row == '0 && o_value == '0)
    else $error("malformed no-match beat");

  a_insert_step: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && cmd == CMD_INSERT && can_push && !full && commit
    |=> row_count == $past(row_count) + RC_W'(1) && cursor == '0)
    else $error("row commit did not advance row count");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && !scan_done |=> !s_tready)
    else $error("input taken during scan");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, update, read and equality scan commands into the row store
// table and checks every result beat against a local model of the table.
// A short directed table comes first, then random phases at several column
// widths, ending with a fill of the table past full.
// ----------------------------------------------------------------------------
module testbench;
  import rsts_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [ROW_W-1:0]   row_index;
    logic [VALUE_W-1:0] value_res;
    status_t            status;
    logic               last;
  } beat_t;

  typedef struct {
    cmd_t               cmd;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] val;
    bit                 typed;
    logic [ROW_W-1:0]   x_row;
    logic [VALUE_W-1:0] x_val;
    status_t            x_st;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  // table model
  logic [VALUE_W-1:0] cells [MAX_ROWS_DEF*MAX_COLUMNS_DEF];
  bit                 written [MAX_ROWS_DEF*MAX_COLUMNS_DEF];
  int                 rows_used;
  int                 cursor;
  logic [CFG_W-1:0]   cols_reg;

  beat_t    pending_beats [$];
  int       errors;
  int       cycles;
  bit       quiet;
  bit       hold_req;
  dir_row_t dir_rows [22];

  row_store_table_scan DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL row_store_table_scan");
      $finish;
    end
  end

  function automatic int eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return int'(cols_reg);
  endfunction

  function automatic void queue_beat(int r, logic [VALUE_W-1:0] v, status_t st, logic l);
    beat_t b;
    b.row_index = ROW_W'(r);
    b.value_res = v;
    b.status    = st;
    b.last      = l;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic void apply_table_cmd(cmd_t cmd, logic [ROW_W-1:0] row,
                                          logic [COL_W-1:0] col, logic [VALUE_W-1:0] val);
    int ncol;
    int cur;
    int hits;
    int addr;
    ncol = eff_cols();
    addr = int'(row) * MAX_COLUMNS_DEF + int'(col);
    case (cmd)
      CMD_INSERT: begin
        if (rows_used >= MAX_ROWS_DEF) begin
          queue_beat(0, '0, ST_FULL, 1'b1);
        end else begin
          cur = cursor % MAX_COLUMNS_DEF;
          cells[rows_used*MAX_COLUMNS_DEF + cur]   = val;
          written[rows_used*MAX_COLUMNS_DEF + cur] = 1'b1;
          queue_beat(rows_used, '0, ST_OK, 1'b1);
          if (cur + 1 >= ncol) begin
            cursor    = 0;
            rows_used = rows_used + 1;
          end else begin
            cursor = cur + 1;
          end
        end
      end
      CMD_UPDATE, CMD_READ: begin
        if (int'(row) >= rows_used || int'(col) >= ncol) begin
          queue_beat(0, '0, ST_RANGE, 1'b1);
        end else if (cmd == CMD_UPDATE) begin
          cells[addr]   = val;
          written[addr] = 1'b1;
          queue_beat(row, '0, ST_OK, 1'b1);
        end else begin
          queue_beat(row, cells[addr], ST_OK, 1'b1);
        end
      end
      default: begin
        hits = 0;
        if (int'(col) >= ncol) begin
          queue_beat(0, '0, ST_RANGE, 1'b1);
        end else begin
          for (int r = 0; r < rows_used; r++) begin
            if (cells[r*MAX_COLUMNS_DEF + int'(col)] == val) begin
              queue_beat(r, '0, ST_OK, 1'b0);
              hits++;
            end
          end
          if (hits == 0) queue_beat(0, '0, ST_NOMATCH, 1'b1);
          else pending_beats[$].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(cmd_t cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                          logic [VALUE_W-1:0] val);
    if (!quiet && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, val, col, row, cmd};
    do @(posedge clk); while (!s_tready);
    apply_table_cmd(cmd, row, col, val);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_columns(logic [CFG_W-1:0] v);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cols_reg = v;
  endtask

  task automatic send_random(int ins_pct);
    cmd_t               cmd;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] val;
    int                 ncol;
    ncol = eff_cols();
    if ($urandom_range(99) < ins_pct) cmd = CMD_INSERT;
    else begin
      case ($urandom_range(2))
        0:       cmd = CMD_UPDATE;
        1:       cmd = CMD_SCAN;
        default: cmd = CMD_READ;
      endcase
    end
    if (rows_used > 0 && $urandom_range(99) < 75) row = ROW_W'($urandom_range(rows_used - 1));
    else row = ROW_W'($urandom_range(63));
    if ($urandom_range(99) < 80) col = COL_W'($urandom_range(ncol - 1));
    else col = COL_W'($urandom_range(7));
    val = pick_value();
    // never touch a cell that has not been written: write it instead
    if (cmd == CMD_READ && int'(row) < rows_used && int'(col) < ncol &&
        !written[int'(row)*MAX_COLUMNS_DEF + int'(col)])
      cmd = CMD_UPDATE;
    if (cmd == CMD_SCAN && int'(col) < ncol) begin
      for (int r = 0; r < rows_used; r++) begin
        if (!written[r*MAX_COLUMNS_DEF + int'(col)]) begin
          cmd = CMD_UPDATE;
          row = ROW_W'(r);
          break;
        end
      end
    end
    send_cmd(cmd, row, col, val);
  endtask

  // result side
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.row_index = m_tdata[5:0];
      got.value_res = m_tdata[37:6];
      got.status    = status_t'(m_tdata[39:38]);
      got.last      = m_tlast;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: row_index %0d status %0d", got.row_index, got.status);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got.row_index !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
          errors++;
        end
        if (got.value_res !== want.value_res) begin
          $error("value_res: expected %h, got %h", want.value_res, got.value_res);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase_cols [6];
    int rand_items;
    int fill_extra;
    phase_cols = '{8, 3, 15, 1, 5, 0};
    rand_items = 0;
    fill_extra = 0;
    errors     = 0;
    cycles     = 0;
    rows_used  = 0;
    cursor     = 0;
    cols_reg   = COLS_RESET;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    dir_rows = '{
      '{CMD_SCAN,   6'd0,  3'd0, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_NOMATCH},
      '{CMD_READ,   6'd0,  3'd0, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE},
      '{CMD_UPDATE, 6'd0,  3'd0, 32'h0000_0001, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE},
      '{CMD_INSERT, 6'd0,  3'd0, 32'h8000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_OK},
      '{CMD_INSERT, 6'd0,  3'd0, 32'h7FFF_FFFF, 1'b1, 6'd0, 32'h0000_0000, ST_OK},
      '{CMD_INSERT, 6'd0,  3'd0, 32'hFFFF_FFFF, 1'b1, 6'd1, 32'h0000_0000, ST_OK},
      '{CMD_INSERT, 6'd0,  3'd0, 32'h0000_0000, 1'b1, 6'd1, 32'h0000_0000, ST_OK},
      '{CMD_READ,   6'd1,  3'd0, 32'h0000_0000, 1'b1, 6'd1, 32'hFFFF_FFFF, ST_OK},
      '{CMD_READ,   6'd0,  3'd1, 32'h0000_0000, 1'b1, 6'd0, 32'h7FFF_FFFF, ST_OK},
      '{CMD_READ,   6'd1,  3'd2, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE},
      '{CMD_READ,   6'd2,  3'd0, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE},
      '{CMD_READ,   6'd63, 3'd7, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE},
      '{CMD_UPDATE, 6'd1,  3'd1, 32'h7FFF_FFFF, 1'b1, 6'd1, 32'h0000_0000, ST_OK},
      '{CMD_SCAN,   6'd0,  3'd1, 32'h7FFF_FFFF, 1'b0, 6'd0, 32'h0000_0000, ST_OK},
      '{CMD_SCAN,   6'd0,  3'd0, 32'h1234_5678, 1'b1, 6'd0, 32'h0000_0000, ST_NOMATCH},
      '{CMD_SCAN,   6'd0,  3'd7, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE},
      '{CMD_UPDATE, 6'd0,  3'd0, 32'hFFFF_FFFF, 1'b1, 6'd0, 32'h0000_0000, ST_OK},
      '{CMD_SCAN,   6'd0,  3'd0, 32'hFFFF_FFFF, 1'b0, 6'd0, 32'h0000_0000, ST_OK},
      '{CMD_INSERT, 6'd63, 3'd7, 32'h5555_AAAA, 1'b1, 6'd2, 32'h0000_0000, ST_OK},
      '{CMD_INSERT, 6'd0,  3'd0, 32'hAAAA_5555, 1'b1, 6'd2, 32'h0000_0000, ST_OK},
      '{CMD_READ,   6'd2,  3'd1, 32'h0000_0000, 1'b1, 6'd2, 32'hAAAA_5555, ST_OK},
      '{CMD_UPDATE, 6'd2,  3'd3, 32'h0000_0000, 1'b1, 6'd0, 32'h0000_0000, ST_RANGE}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at two columns per row
    write_columns(CFG_W'(2));
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].row, dir_rows[i].col, dir_rows[i].val);
      if (dir_rows[i].typed) begin
        pending_beats[$].row_index = dir_rows[i].x_row;
        pending_beats[$].value_res = dir_rows[i].x_val;
        pending_beats[$].status    = dir_rows[i].x_st;
      end
    end

    // random phases; the last one fills the table past full
    for (int p = 0; p < 6; p++) begin
      write_columns(CFG_W'(phase_cols[p]));
      quiet = (p == 2);
      if (p < 5) begin
        repeat (40) begin
          send_random(40);
          rand_items++;
          if (rand_items == 60) wait_drain();
          if (rand_items == 100) hold_req = 1'b1;
        end
      end else begin
        while (fill_extra < 20) begin
          send_random(70);
          if (rows_used >= MAX_ROWS_DEF) fill_extra++;
        end
      end
    end
    quiet = 1'b0;

    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS row_store_table_scan");
    end else begin
      $display("FAIL row_store_table_scan");
    end
    $finish;
  end

endmodule
